### hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tcw_pkg.sv
// types, codes and constants of the text console writer
package tcw_pkg;

    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int OFS_W    = 11;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_OFF = 2'd1;

    localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_BS        = 8'h08;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TILDE     = 8'h7E;
    localparam logic [BYTE_W-1:0] DEFAULT_ATTR = 8'h4F;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_BS_WR,
        ST_RD_CAP,
        ST_SWEEP,
        ST_DONE
    } tcw_state_t;

    typedef struct packed {
        logic in_ready;
        logic load_in;
        logic wr_print;
        logic wr_blank_char;
        logic cur_home;
        logic cur_cr;
        logic cur_adv;
        logic cur_down;
        logic cur_back;
        logic sweep_start;
        logic sweep_scroll;
        logic sweep_step;
        logic rd_cell;
        logic cap_read;
        logic out_load;
    } tcw_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            is_lf;
        logic            is_cr;
        logic            is_bs;
        logic            is_print;
        logic            at_origin;
        logic            row_last;
        logic            col_last;
        logic            sweep_done;
        logic            out_free;
    } tcw_status_t;

endpackage

### hdl/tcw_ctrl.sv
// controller state machine of the text console writer
module tcw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd
);

    tcw_pkg::tcw_state_t state_reg;
    tcw_pkg::tcw_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcw_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            tcw_pkg::ST_INIT: begin
                if (status.sweep_done) begin
                    state_next = tcw_pkg::ST_IDLE;
                end else begin
                    cmd.sweep_step = 1'b1;
                end
            end
            tcw_pkg::ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC: begin
                state_next = tcw_pkg::ST_DONE;
                case (status.op)
                    tcw_pkg::OP_PUT: begin
                        if (status.is_print) begin
                            cmd.wr_print = 1'b1;
                            if (!status.col_last) begin
                                cmd.cur_adv = 1'b1;
                            end else if (!status.row_last) begin
                                cmd.cur_down = 1'b1;
                            end else begin
                                cmd.cur_cr       = 1'b1;
                                cmd.sweep_start  = 1'b1;
                                cmd.sweep_scroll = 1'b1;
                                state_next       = tcw_pkg::ST_SWEEP;
                            end
                        end else if (status.is_lf) begin
                            if (!status.row_last) begin
                                cmd.cur_down = 1'b1;
                            end else begin
                                cmd.cur_cr       = 1'b1;
                                cmd.sweep_start  = 1'b1;
                                cmd.sweep_scroll = 1'b1;
                                state_next       = tcw_pkg::ST_SWEEP;
                            end
                        end else if (status.is_cr) begin
                            cmd.cur_cr = 1'b1;
                        end else if (status.is_bs && !status.at_origin) begin
                            cmd.cur_back = 1'b1;
                            state_next   = tcw_pkg::ST_BS_WR;
                        end
                    end
                    tcw_pkg::OP_READ: begin
                        cmd.rd_cell = 1'b1;
                        state_next  = tcw_pkg::ST_RD_CAP;
                    end
                    tcw_pkg::OP_CLEAR: begin
                        cmd.cur_home    = 1'b1;
                        cmd.sweep_start = 1'b1;
                        state_next      = tcw_pkg::ST_SWEEP;
                    end
                    default: begin
                        state_next = tcw_pkg::ST_DONE;
                    end
                endcase
            end
            tcw_pkg::ST_BS_WR: begin
                cmd.wr_blank_char = 1'b1;
                state_next        = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_RD_CAP: begin
                cmd.cap_read = 1'b1;
                state_next   = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_SWEEP: begin
                if (status.sweep_done) begin
                    state_next = tcw_pkg::ST_DONE;
                end else begin
                    cmd.sweep_step = 1'b1;
                end
            end
            tcw_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/tcw_dp.sv
// datapath of the text console writer: screen store, cursor, sweep pointers, result register
module tcw_dp #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tcw_pkg::tcw_cmd_t               cmd,
    output tcw_pkg::tcw_status_t            status,
    input  logic [tcw_pkg::OP_W-1:0]        s_tuser,
    input  logic [tcw_pkg::IN_W-1:0]        s_tdata,
    input  logic                            cfg_valid,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcw_pkg::BYTE_W-1:0]      cfg_data,
    output logic [tcw_pkg::OUT_W-1:0]       m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready
);

    localparam int NCELLS = ROWS * COLS;
    localparam int AW     = $clog2(NCELLS);
    localparam int CW     = $clog2(NCELLS + 1);
    localparam int LW     = (AW > tcw_pkg::OFS_W) ? AW : tcw_pkg::OFS_W;

    logic [tcw_pkg::BYTE_W-1:0] char_mem [NCELLS];
    logic [tcw_pkg::BYTE_W-1:0] attr_mem [NCELLS];

    logic [tcw_pkg::OP_W-1:0]   op_reg;
    logic [tcw_pkg::BYTE_W-1:0] byte_reg;
    logic [tcw_pkg::ROW_W-1:0]  cell_row_reg;
    logic [tcw_pkg::COL_W-1:0]  cell_col_reg;

    logic [tcw_pkg::ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [tcw_pkg::COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [tcw_pkg::BYTE_W-1:0] text_color_reg;
    logic                       cursor_off_reg;

    logic [CW-1:0]              wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]              rd_ptr_reg, rd_ptr_next;
    logic                       pend_reg, pend_next;

    logic [tcw_pkg::BYTE_W-1:0] char_rd_reg;
    logic [tcw_pkg::BYTE_W-1:0] attr_rd_reg;
    logic [tcw_pkg::BYTE_W-1:0] res_byte_reg;
    logic [tcw_pkg::OUT_W-1:0]  m_data_reg;
    logic                       m_valid_reg;

    logic [LW-1:0]              cur_lin;
    logic [LW-1:0]              cell_lin;
    logic                       cell_in_range;
    logic                       rd_done;

    logic                       we_char, we_attr, re;
    logic [AW-1:0]              waddr, raddr;
    logic [tcw_pkg::BYTE_W-1:0] wchar, wattr;

    assign cur_lin  = LW'(cur_row_reg) * LW'(COLS) + LW'(cur_col_reg);
    assign cell_lin = LW'(cell_row_reg) * LW'(COLS) + LW'(cell_col_reg);
    assign cell_in_range = (int'(cell_row_reg) < ROWS) && (int'(cell_col_reg) < COLS);
    assign rd_done  = (rd_ptr_reg == CW'(NCELLS));

    // status toward the controller
    always_comb begin
        status.op         = op_reg;
        status.is_lf      = (byte_reg == tcw_pkg::CH_LF);
        status.is_cr      = (byte_reg == tcw_pkg::CH_CR);
        status.is_bs      = (byte_reg == tcw_pkg::CH_BS);
        status.is_print   = (byte_reg >= tcw_pkg::CH_SPACE) && (byte_reg <= tcw_pkg::CH_TILDE);
        status.at_origin  = (cur_row_reg == '0) && (cur_col_reg == '0);
        status.row_last   = (int'(cur_row_reg) == ROWS - 1);
        status.col_last   = (int'(cur_col_reg) == COLS - 1);
        status.sweep_done = (wr_ptr_reg == CW'(NCELLS));
        status.out_free   = !m_valid_reg || m_tready;
    end

    // cursor update
    always_comb begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        if (cmd.cur_home) begin
            cur_row_next = '0;
            cur_col_next = '0;
        end else if (cmd.cur_cr) begin
            cur_col_next = '0;
        end else if (cmd.cur_adv) begin
            cur_col_next = cur_col_reg + 1'b1;
        end else if (cmd.cur_down) begin
            cur_row_next = cur_row_reg + 1'b1;
            cur_col_next = '0;
        end else if (cmd.cur_back) begin
            if (cur_col_reg == '0) begin
                cur_row_next = cur_row_reg - 1'b1;
                cur_col_next = tcw_pkg::COL_W'(COLS - 1);
            end else begin
                cur_col_next = cur_col_reg - 1'b1;
            end
        end
    end

    // sweep pointers: copy from one row down, then blank the tail (all cells on clear)
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        pend_next   = pend_reg;
        if (cmd.sweep_start) begin
            wr_ptr_next = '0;
            rd_ptr_next = cmd.sweep_scroll ? CW'(COLS) : CW'(NCELLS);
            pend_next   = 1'b0;
        end else if (cmd.sweep_step) begin
            if (pend_reg || rd_done) begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
            if (!rd_done) begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
            pend_next = !rd_done;
        end
    end

    // store port control
    always_comb begin
        we_char = 1'b0;
        we_attr = 1'b0;
        re      = 1'b0;
        waddr   = cur_lin[AW-1:0];
        raddr   = cell_lin[AW-1:0];
        wchar   = byte_reg;
        wattr   = text_color_reg;
        if (cmd.wr_print) begin
            we_char = 1'b1;
            we_attr = 1'b1;
        end else if (cmd.wr_blank_char) begin
            we_char = 1'b1;
            wchar   = tcw_pkg::CH_SPACE;
        end else if (cmd.sweep_step) begin
            waddr = wr_ptr_reg[AW-1:0];
            raddr = rd_ptr_reg[AW-1:0];
            re    = !rd_done;
            if (pend_reg) begin
                we_char = 1'b1;
                we_attr = 1'b1;
                wchar   = char_rd_reg;
                wattr   = attr_rd_reg;
            end else if (rd_done) begin
                we_char = 1'b1;
                we_attr = 1'b1;
                wchar   = tcw_pkg::CH_SPACE;
                wattr   = tcw_pkg::DEFAULT_ATTR;
            end
        end else if (cmd.rd_cell) begin
            re = cell_in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (we_char) begin
            char_mem[waddr] <= wchar;
        end
        if (we_attr) begin
            attr_mem[waddr] <= wattr;
        end
        if (re) begin
            char_rd_reg <= char_mem[raddr];
            attr_rd_reg <= attr_mem[raddr];
        end
    end

    // input beat capture, result byte and result word
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg       <= s_tuser;
            byte_reg     <= s_tdata[7:0];
            cell_row_reg <= s_tdata[12:8];
            cell_col_reg <= s_tdata[19:13];
            res_byte_reg <= (s_tuser == tcw_pkg::OP_PUT) ? s_tdata[7:0] : '0;
        end else if (cmd.cap_read) begin
            res_byte_reg <= cell_in_range ? char_rd_reg : '0;
        end
        if (cmd.out_load) begin
            m_data_reg <= {~cursor_off_reg, cur_lin[tcw_pkg::OFS_W-1:0],
                           cur_col_reg, cur_row_reg, res_byte_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            text_color_reg <= tcw_pkg::DEFAULT_ATTR;
            cursor_off_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= CW'(NCELLS);
            pend_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            pend_reg    <= pend_next;
            if (cfg_valid) begin
                case (cfg_index)
                    tcw_pkg::CFG_TEXT_COLOR: begin
                        text_color_reg <= cfg_data;
                    end
                    tcw_pkg::CFG_CURSOR_OFF: begin
                        cursor_off_reg <= cfg_data[0];
                    end
                    default: begin
                        text_color_reg <= text_color_reg;
                    end
                endcase
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tdata  = m_data_reg;
    assign m_tvalid = m_valid_reg;

endmodule

### hdl/text_console_writer.sv
// top level of the text console writer
//
// Character-cell screen of ROWS x COLS cells with a cursor. Each input beat
// on the s_ channel carries an operation in s_tuser (put byte, read cell,
// clear screen) and its operands in s_tdata; exactly one result beat leaves
// on the m_ channel with the result byte, the cursor row and column, the
// linear cursor offset and the cursor-shown flag.
// The cfg channel writes text_color (index 0) and the cursor-off flag
// (index 1); write it only while no operation is in flight.
// Flow: an accepted beat goes to the execute state; backspace away from the
// origin then passes the blank-write state, read the capture state, and a
// put that scrolls or a clear the walk over the screen store, one cell per
// cycle; then the done state loads the result register and m_tvalid rises.
// One operation is worked on at a time; the next beat is taken in the cycle
// after the result is loaded.
// After aresetn the screen store is blanked in a pass over all ROWS*COLS
// cells, during which s_tready stays low; cfg writes are taken at all times.
// When the receiver stalls, the result is held in the output register and
// the next beat can still be accepted; it waits for the register to free.
`include "assert_macros.svh"

module text_console_writer #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // byte_value[7:0], cell_row[12:8], cell_col[19:13], zero[23:20]
    input  logic [tcw_pkg::IN_W-1:0]      s_tdata,
    // operation[1:0]
    input  logic [tcw_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_byte[7:0], cursor_row_out[12:8], cursor_col_out[19:13],
    // cursor_offset[30:20], cursor_shown[31]
    output logic [tcw_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcw_pkg::BYTE_W-1:0]    cfg_data
);

    tcw_pkg::tcw_cmd_t    cmd;
    tcw_pkg::tcw_status_t status;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

    assign s_tready  = cmd.in_ready;
    assign cfg_ready = 1'b1;

    `ASSERT_NOW(a_row_in_range, aclk, aresetn, m_tvalid, int'(m_tdata[12:8]) < ROWS, "row off")
    `ASSERT_NOW(a_col_in_range, aclk, aresetn, m_tvalid, int'(m_tdata[19:13]) < COLS, "col off")
    `ASSERT_NOW(a_no_accept_in_sweep, aclk, aresetn, cmd.sweep_step, !s_tready, "beat in sweep")
    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second beat")

endmodule
